FILE: sv/kwsc_pkg.sv
// Shared types, constants and helper functions for the keyword substitution cipher.
// No dependencies; compiled before the interfaces and the core.
package kwsc_pkg;

    localparam int NUM_LETTERS = 26;
    localparam int LETTER_W    = 5;
    localparam int BYTE_W      = 8;
    localparam int CMD_W       = 2;

    typedef logic [LETTER_W-1:0]    letter_t;
    typedef logic [NUM_LETTERS-1:0] letter_mask_t;
    typedef logic [BYTE_W-1:0]      byte_t;
    typedef logic [CMD_W-1:0]       cmd_t;

    // Command codes carried in the cmd field of an input item.
    localparam cmd_t CMD_CLEAR = 2'd0;
    localparam cmd_t CMD_KEY   = 2'd1;
    localparam cmd_t CMD_TEXT  = 2'd2;

    localparam byte_t ASCII_LOWER_A = 8'h61;
    localparam byte_t ASCII_LOWER_Z = 8'h7a;
    localparam byte_t ASCII_UPPER_A = 8'h41;
    localparam byte_t ASCII_UPPER_Z = 8'h5a;

    localparam letter_t LAST_LETTER = letter_t'(NUM_LETTERS - 1);

    // Number of set bits in a letter mask; the result never exceeds 26.
    function automatic letter_t count_ones(letter_mask_t m);
        letter_t acc;
        acc = '0;
        for (int j = 0; j < NUM_LETTERS; j++)
        begin
            acc = acc + letter_t'(m[j]);
        end
        return acc;
    endfunction

    // Mask of the letters whose index lies below the offset. Offsets of 26 and
    // above give all ones, which is the same as clamping the offset to 26.
    function automatic letter_mask_t below_mask(letter_t off);
        letter_mask_t m;
        for (int j = 0; j < NUM_LETTERS; j++)
        begin
            m[j] = (letter_t'(j) < off);
        end
        return m;
    endfunction

endpackage

FILE: sv/kwsc_req_if.sv
// Input channel of the keyword substitution cipher: valid/ready plus cmd and ch.
// Depends on kwsc_pkg.
interface kwsc_req_if;
    logic           valid;
    logic           ready;
    kwsc_pkg::cmd_t cmd;
    kwsc_pkg::byte_t ch;

    modport source (output valid, output cmd, output ch, input ready);
    modport sink   (input valid, input cmd, input ch, output ready);
endinterface

FILE: sv/kwsc_resp_if.sv
// Result channel of the keyword substitution cipher: valid/ready plus out_ch.
// Depends on kwsc_pkg.
interface kwsc_resp_if;
    logic            valid;
    logic            ready;
    kwsc_pkg::byte_t out_ch;

    modport source (output valid, output out_ch, input ready);
    modport sink   (input valid, input out_ch, output ready);
endinterface

FILE: sv/keyword_substitution_cipher_core.sv
// Top level of the keyword substitution cipher: keyword store, free-letter list
// and the one-pass text mapping. Depends on kwsc_pkg, kwsc_req_if, kwsc_resp_if.
//
//   Channel   Kind        Handshake            Payload
//   req       item in     valid/ready          cmd[1:0], ch[7:0]
//   resp      item out    valid/ready          out_ch[7:0]
//   cfg       register    cfg_we, no stall     cfg_wdata[4:0] = key_offset
//
// Every item passes through the input register, and a text item then through
// the result register before its byte appears on resp; a text item can wait
// in either register. One item is accepted per cycle when resp is not stalled.
// The per-item path is the 26-bit free-letter count and a 26-to-1 selection from the keyword or the free list.
// rst_n (asynchronous, active low) empties both registers, clears the keyword
// and sets key_offset to zero; no clearing pass is needed.
// A stall on resp holds the result; the input register still drains keyword,
// clear and unused items, and holds a text item until the result register frees.
module keyword_substitution_cipher_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  kwsc_pkg::letter_t     cfg_wdata,
    kwsc_req_if.sink              req,
    kwsc_resp_if.source           resp
);

    // Configuration register. Any offset of 26 or more acts as 26.
    kwsc_pkg::letter_t key_offset_reg;

    // Input register.
    logic              s1_valid_reg;
    kwsc_pkg::cmd_t    s1_cmd_reg;
    kwsc_pkg::byte_t   s1_ch_reg;

    // Result register.
    logic              out_valid_reg;
    logic              out_valid_next;
    kwsc_pkg::byte_t   out_ch_reg;

    // Keyword state. The keyword letters are stored in arrival order. The free
    // list holds, in ascending order, every letter that is not in the keyword;
    // only its first 26 - key_count entries are meaningful.
    kwsc_pkg::letter_t    key_letters_reg [kwsc_pkg::NUM_LETTERS];
    kwsc_pkg::letter_t    key_count_reg;
    kwsc_pkg::letter_t    key_count_next;
    kwsc_pkg::letter_mask_t key_seen_mask_reg;
    kwsc_pkg::letter_mask_t key_seen_mask_next;
    kwsc_pkg::letter_t    free_list_reg  [kwsc_pkg::NUM_LETTERS];
    kwsc_pkg::letter_t    free_list_next [kwsc_pkg::NUM_LETTERS];

    logic              out_can_load;
    logic              s1_fire;
    logic              key_write;

    // Keyword byte decode.
    kwsc_pkg::byte_t   key_lc;
    logic              key_is_letter;
    kwsc_pkg::letter_t key_idx;

    // Text byte mapping.
    logic              txt_is_lower;
    logic              txt_is_upper;
    kwsc_pkg::byte_t   txt_base;
    kwsc_pkg::letter_t txt_idx;
    kwsc_pkg::letter_t pre_count;
    logic [kwsc_pkg::LETTER_W:0] key_end;
    kwsc_pkg::letter_t free_rank;
    kwsc_pkg::letter_t cipher_idx;
    kwsc_pkg::byte_t   txt_result;

    // ------------------------------------------------------------------
    // Flow control. Only a text item needs room in the result register.
    // ------------------------------------------------------------------
    assign out_can_load = !out_valid_reg || resp.ready;
    assign s1_fire      = s1_valid_reg &&
                          ((s1_cmd_reg != kwsc_pkg::CMD_TEXT) || out_can_load);
    assign req.ready    = !s1_valid_reg || s1_fire;

    assign resp.valid   = out_valid_reg;
    assign resp.out_ch  = out_ch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            key_offset_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_cmd_reg <= req.cmd;
            s1_ch_reg  <= req.ch;
        end
    end

    // ------------------------------------------------------------------
    // Keyword update. A new letter is appended to the keyword and removed
    // from the free list; because the list is sorted, every entry at or
    // above the removed letter moves down by one place.
    // ------------------------------------------------------------------
    always_comb
    begin
        key_lc = s1_ch_reg;
        if ((s1_ch_reg >= kwsc_pkg::ASCII_UPPER_A) && (s1_ch_reg <= kwsc_pkg::ASCII_UPPER_Z))
        begin
            key_lc = s1_ch_reg - kwsc_pkg::ASCII_UPPER_A + kwsc_pkg::ASCII_LOWER_A;
        end
        key_is_letter = (key_lc >= kwsc_pkg::ASCII_LOWER_A) &&
                        (key_lc <= kwsc_pkg::ASCII_LOWER_Z);
        key_idx       = kwsc_pkg::letter_t'(key_lc - kwsc_pkg::ASCII_LOWER_A);
    end

    assign key_write = s1_fire && (s1_cmd_reg == kwsc_pkg::CMD_KEY) && key_is_letter &&
                       !key_seen_mask_reg[key_idx] &&
                       (key_count_reg < kwsc_pkg::letter_t'(kwsc_pkg::NUM_LETTERS));

    always_comb
    begin
        key_count_next     = key_count_reg;
        key_seen_mask_next = key_seen_mask_reg;
        for (int k = 0; k < kwsc_pkg::NUM_LETTERS; k++)
        begin
            free_list_next[k] = free_list_reg[k];
        end

        if (s1_fire && (s1_cmd_reg == kwsc_pkg::CMD_CLEAR))
        begin
            key_count_next     = '0;
            key_seen_mask_next = '0;
            for (int k = 0; k < kwsc_pkg::NUM_LETTERS; k++)
            begin
                free_list_next[k] = kwsc_pkg::letter_t'(k);
            end
        end
        else if (key_write)
        begin
            key_count_next              = key_count_reg + kwsc_pkg::letter_t'(1);
            key_seen_mask_next[key_idx] = 1'b1;
            for (int k = 0; k < kwsc_pkg::NUM_LETTERS - 1; k++)
            begin
                if (free_list_reg[k] >= key_idx)
                begin
                    free_list_next[k] = free_list_reg[k + 1];
                end
            end
            free_list_next[kwsc_pkg::NUM_LETTERS - 1] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg     <= '0;
            key_seen_mask_reg <= '0;
            for (int k = 0; k < kwsc_pkg::NUM_LETTERS; k++)
            begin
                free_list_reg[k] <= kwsc_pkg::letter_t'(k);
            end
        end
        else
        begin
            key_count_reg     <= key_count_next;
            key_seen_mask_reg <= key_seen_mask_next;
            for (int k = 0; k < kwsc_pkg::NUM_LETTERS; k++)
            begin
                free_list_reg[k] <= free_list_next[k];
            end
        end
    end

    // Keyword letters carry no reset; only entries below key_count are read.
    always_ff @(posedge clk)
    begin
        if (key_write)
        begin
            key_letters_reg[key_count_reg] <= key_idx;
        end
    end

    // ------------------------------------------------------------------
    // Text mapping. The cipher alphabet is the free letters below the
    // offset, then the keyword, then the remaining free letters. Both free
    // runs are consecutive ranks of the sorted free list, so a plain letter
    // outside the keyword window maps to free rank i (before it) or
    // i - key_count (after it).
    // ------------------------------------------------------------------
    always_comb
    begin
        txt_is_lower = (s1_ch_reg >= kwsc_pkg::ASCII_LOWER_A) &&
                       (s1_ch_reg <= kwsc_pkg::ASCII_LOWER_Z);
        txt_is_upper = (s1_ch_reg >= kwsc_pkg::ASCII_UPPER_A) &&
                       (s1_ch_reg <= kwsc_pkg::ASCII_UPPER_Z);
        txt_base     = txt_is_lower ? kwsc_pkg::ASCII_LOWER_A : kwsc_pkg::ASCII_UPPER_A;
        txt_idx      = kwsc_pkg::letter_t'(s1_ch_reg - txt_base);

        pre_count = kwsc_pkg::count_ones(~key_seen_mask_reg &
                                         kwsc_pkg::below_mask(key_offset_reg));
        key_end   = {1'b0, pre_count} + {1'b0, key_count_reg};

        free_rank = txt_idx - key_count_reg;
        if (txt_idx < pre_count)
        begin
            free_rank = txt_idx;
        end

        if ((txt_idx >= pre_count) && ({1'b0, txt_idx} < key_end))
        begin
            cipher_idx = key_letters_reg[txt_idx - pre_count];
        end
        else
        begin
            cipher_idx = free_list_reg[free_rank];
        end

        txt_result = s1_ch_reg;
        if (txt_is_lower || txt_is_upper)
        begin
            txt_result = txt_base + kwsc_pkg::byte_t'(cipher_idx);
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire && (s1_cmd_reg == kwsc_pkg::CMD_TEXT))
        begin
            out_valid_next = 1'b1;
        end
        else if (resp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && (s1_cmd_reg == kwsc_pkg::CMD_TEXT))
        begin
            out_ch_reg <= txt_result;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The keyword length always equals the number of letters marked as seen.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(key_seen_mask_reg) == int'(key_count_reg))
        else $error("key_count disagrees with seen mask");

    // The keyword never grows past the alphabet.
    assert property (@(posedge clk) disable iff (!rst_n)
        key_count_reg <= kwsc_pkg::letter_t'(kwsc_pkg::NUM_LETTERS))
        else $error("key_count above alphabet size");

    // A clear item empties the keyword.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (s1_cmd_reg == kwsc_pkg::CMD_CLEAR)) |=> (key_count_reg == '0))
        else $error("clear item did not empty keyword");

    // A result only appears after a text item leaves the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_fire && (s1_cmd_reg == kwsc_pkg::CMD_TEXT)))
        else $error("result without a text item");

    // A stalled text item is never dropped from the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_cmd_reg == kwsc_pkg::CMD_TEXT) && !out_can_load)
        |=> (s1_valid_reg && $stable(s1_ch_reg)))
        else $error("stalled text item lost");

endmodule
